// ----- rtl/ucm_pkg.sv -----
// ----------------------------------------------------------------------------
// ucm_pkg: shared types and constants of the crossover and mutation unit
// Holds the configuration register map, the threshold set, the result item
// layout and the saturating counter helper used by the datapath.
// ----------------------------------------------------------------------------
package ucm_pkg;

   // Longest chromosome the block is built for.
   localparam int MAX_FEATURES = 4096;

   // Field widths.
   localparam int DRAW_W  = 16;
   localparam int THR_W   = 17;
   localparam int INDEX_W = 12;
   localparam int COUNT_W = 13;

   // The counters saturate at the chromosome length, held within their width.
   localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
   localparam int COUNT_CAP = (MAX_FEATURES > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX
                                                                : MAX_FEATURES;

   // Configuration register map.
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_CROSSOVER_THR = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_SWAP_THR      = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_MUTATE_THR    = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_SET_ONE_THR   = CSR_INDEX_W'(3);

   // Reset values of the thresholds (probabilities scaled by 65536).
   localparam logic [THR_W-1:0] CROSSOVER_THR_RST = THR_W'(49152);
   localparam logic [THR_W-1:0] SWAP_THR_RST      = THR_W'(32768);
   localparam logic [THR_W-1:0] MUTATE_THR_RST    = THR_W'(6554);
   localparam logic [THR_W-1:0] SET_ONE_THR_RST   = THR_W'(655);

   // Threshold set handed from the register file to the datapath.
   typedef struct packed {
      logic [THR_W-1:0] crossover;
      logic [THR_W-1:0] swap;
      logic [THR_W-1:0] mutate;
      logic [THR_W-1:0] set_one;
   } thresholds_type;

   // One result item.
   typedef struct packed {
      logic               child_a_bit;
      logic               child_b_bit;
      logic               two_children;
      logic               last_result;
      logic [COUNT_W-1:0] count_a;
      logic [COUNT_W-1:0] count_b;
      logic               force_a;
      logic               force_b;
      logic [INDEX_W-1:0] force_index_a;
      logic [INDEX_W-1:0] force_index_b;
   } result_type;

   // Adds one to a ones count when the bit is set, holding at the cap.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] count,
                                                  input logic               bit_set);
      logic [COUNT_W-1:0] result;
      result = count;
      if (bit_set) begin
         result = (count >= COUNT_W'(COUNT_CAP)) ? COUNT_W'(COUNT_CAP)
                                                 : count + COUNT_W'(1);
      end
      return result;
   endfunction

endpackage

// ----- rtl/ucm_if.sv -----
// ----------------------------------------------------------------------------
// ucm_if: channel interfaces of the crossover and mutation unit
// Feature request channel, result channel and configuration write channel,
// each with valid/ready flow control and a source and a sink modport.
// ----------------------------------------------------------------------------

// Feature request channel: one feature of the offspring per transfer.
interface ucm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        bit_a;
   logic                        bit_b;
   logic [ucm_pkg::DRAW_W-1:0]  draw_mode;
   logic [ucm_pkg::DRAW_W-1:0]  draw_main;
   logic [ucm_pkg::DRAW_W-1:0]  draw_second;
   logic [ucm_pkg::INDEX_W-1:0] fix_index_a;
   logic [ucm_pkg::INDEX_W-1:0] fix_index_b;
   logic                        first_feature;
   logic                        last_feature;

   modport source (output valid, bit_a, bit_b, draw_mode, draw_main, draw_second,
                   fix_index_a, fix_index_b, first_feature, last_feature,
                   input ready);
   modport sink   (input valid, bit_a, bit_b, draw_mode, draw_main, draw_second,
                   fix_index_a, fix_index_b, first_feature, last_feature,
                   output ready);
endinterface

// Result channel: one child feature per transfer.
interface ucm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        child_a_bit;
   logic                        child_b_bit;
   logic                        two_children;
   logic                        last_result;
   logic [ucm_pkg::COUNT_W-1:0] count_a;
   logic [ucm_pkg::COUNT_W-1:0] count_b;
   logic                        force_a;
   logic                        force_b;
   logic [ucm_pkg::INDEX_W-1:0] force_index_a;
   logic [ucm_pkg::INDEX_W-1:0] force_index_b;

   modport source (output valid, child_a_bit, child_b_bit, two_children, last_result,
                   count_a, count_b, force_a, force_b, force_index_a, force_index_b,
                   input ready);
   modport sink   (input valid, child_a_bit, child_b_bit, two_children, last_result,
                   count_a, count_b, force_a, force_b, force_index_a, force_index_b,
                   output ready);
endinterface

// Configuration write channel.
interface ucm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ucm_pkg::CSR_INDEX_W-1:0] index;
   logic [ucm_pkg::THR_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/ucm_csr.sv -----
// ----------------------------------------------------------------------------
// ucm_csr: threshold register file
// Takes configuration writes on every cycle and presents the four
// thresholds to the datapath. Writes to unmapped indexes are dropped.
// ----------------------------------------------------------------------------
module ucm_csr (
   input  logic                    clock,
   input  logic                    reset,
   ucm_csr_if.sink                 csr_ch,
   output ucm_pkg::thresholds_type thresholds
);

   ucm_pkg::thresholds_type thr_ff;
   ucm_pkg::thresholds_type thr_in;
   logic                    write_en;

   // The register file never stalls a write.
   assign csr_ch.ready = 1'b1;
   assign write_en     = csr_ch.valid & csr_ch.ready;

   // Decode the register index of a write transfer.
   always_comb begin
      thr_in = thr_ff;
      if (write_en) begin
         unique case (csr_ch.index)
            ucm_pkg::REG_CROSSOVER_THR: thr_in.crossover = csr_ch.data;
            ucm_pkg::REG_SWAP_THR:      thr_in.swap      = csr_ch.data;
            ucm_pkg::REG_MUTATE_THR:    thr_in.mutate    = csr_ch.data;
            ucm_pkg::REG_SET_ONE_THR:   thr_in.set_one   = csr_ch.data;
            default:                    thr_in           = thr_ff;
         endcase
      end
   end

   // Threshold registers with their default probabilities after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.crossover <= ucm_pkg::CROSSOVER_THR_RST;
         thr_ff.swap      <= ucm_pkg::SWAP_THR_RST;
         thr_ff.mutate    <= ucm_pkg::MUTATE_THR_RST;
         thr_ff.set_one   <= ucm_pkg::SET_ONE_THR_RST;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign thresholds = thr_ff;

endmodule

// ----- rtl/ucm_core.sv -----
// ----------------------------------------------------------------------------
// ucm_core: per-feature crossover and mutation datapath
// Works out one child feature from the parent bits and the random draws,
// keeps the offspring mode and the running ones counts, and repairs an
// empty child on the last feature.
// ----------------------------------------------------------------------------
module ucm_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   ucm_req_if.sink                 req_ch,
   input  ucm_pkg::thresholds_type thresholds,
   output ucm_pkg::result_type     result
);

   logic                        mode_ff;
   logic                        mode_in;
   logic [ucm_pkg::COUNT_W-1:0] count_a_ff;
   logic [ucm_pkg::COUNT_W-1:0] count_a_in;
   logic [ucm_pkg::COUNT_W-1:0] count_b_ff;
   logic [ucm_pkg::COUNT_W-1:0] count_b_in;
   logic [ucm_pkg::COUNT_W-1:0] base_a;
   logic [ucm_pkg::COUNT_W-1:0] base_b;
   logic [ucm_pkg::COUNT_W-1:0] run_a;
   logic [ucm_pkg::COUNT_W-1:0] run_b;
   logic                        mode_cur;
   logic                        child_a;
   logic                        child_b;
   logic                        swap_bits;
   logic                        mutate_bit;
   logic                        set_one;
   logic                        empty_a;
   logic                        empty_b;

   // A first feature picks the mode and restarts both counts.
   assign mode_cur = req_ch.first_feature
                   ? ({1'b0, req_ch.draw_mode} < thresholds.crossover) : mode_ff;
   assign base_a   = req_ch.first_feature ? '0 : count_a_ff;
   assign base_b   = req_ch.first_feature ? '0 : count_b_ff;

   // Swap and mutate decisions of this feature.
   assign swap_bits  = (req_ch.bit_a != req_ch.bit_b)
                     & ({1'b0, req_ch.draw_main} < thresholds.swap);
   assign mutate_bit = {1'b0, req_ch.draw_main} < thresholds.mutate;
   assign set_one    = {1'b0, req_ch.draw_second} <= thresholds.set_one;

   // Child bits: uniform crossover, or random-reset mutation of the one parent.
   always_comb begin
      if (mode_cur) begin
         child_a = swap_bits ? req_ch.bit_b : req_ch.bit_a;
         child_b = swap_bits ? req_ch.bit_a : req_ch.bit_b;
      end else begin
         child_a = mutate_bit ? set_one : req_ch.bit_a;
         child_b = 1'b0;
      end
   end

   // Running ones counts; the second child exists only in crossover.
   assign run_a = ucm_pkg::sat_inc(base_a, child_a);
   assign run_b = mode_cur ? ucm_pkg::sat_inc(base_b, child_b) : '0;

   // Empty-child repair on the last feature.
   assign empty_a = req_ch.last_feature & (run_a == '0);
   assign empty_b = req_ch.last_feature & mode_cur & (run_b == '0);

   assign count_a_in = empty_a ? ucm_pkg::COUNT_W'(1) : run_a;
   assign count_b_in = empty_b ? ucm_pkg::COUNT_W'(1) : run_b;
   assign mode_in    = mode_cur;

   // Result item of this feature.
   always_comb begin
      result.child_a_bit   = child_a;
      result.child_b_bit   = child_b;
      result.two_children  = mode_cur;
      result.last_result   = req_ch.last_feature;
      result.count_a       = count_a_in;
      result.count_b       = count_b_in;
      result.force_a       = empty_a;
      result.force_b       = empty_b;
      result.force_index_a = empty_a ? req_ch.fix_index_a : '0;
      result.force_index_b = empty_b ? req_ch.fix_index_b : '0;
   end

   // Offspring state advances on every accepted feature.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end

endmodule

// ----- rtl/uniform_crossover_mutation_unit.sv -----
// ----------------------------------------------------------------------------
// uniform_crossover_mutation_unit: offspring builder for feature selection
// Streams one chromosome feature per transfer and returns the child bits,
// the running ones counts and the empty-child repair of the offspring.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one feature per transfer: the parent bits, three 16-bit
//   uniform draws, the repair indexes and the first/last feature marks.
//   rsp_ch returns exactly one result per accepted feature, in order.
//   csr_ch writes the four 17-bit thresholds by index; it is always ready
//   and should only be written while no feature is in flight.
// Registers and throughput:
//   The datapath is combinational; a result goes to the output register, or
//   to the skid register while the output register holds a stalled result.
//   One feature can be accepted in every cycle while the skid is empty.
// Reset:
//   The thresholds return to 0.75, 0.5, 0.1 and 0.01 (scaled by 65536), the
//   mode to mutation and both counts to zero; no result is pending.
// Stalls:
//   An output register and a skid register hold up to two results, so a
//   feature is still taken in the cycle in which the receiver first stalls;
//   req_ch.ready drops only while the skid register is occupied.
// ----------------------------------------------------------------------------
module uniform_crossover_mutation_unit (
   input  logic      clock,
   input  logic      reset,
   ucm_req_if.sink   req_ch,
   ucm_rsp_if.source rsp_ch,
   ucm_csr_if.sink   csr_ch
);

   ucm_pkg::thresholds_type thresholds;
   ucm_pkg::result_type     result;
   ucm_pkg::result_type     out_data_ff;
   ucm_pkg::result_type     out_data_in;
   ucm_pkg::result_type     skid_data_ff;
   ucm_pkg::result_type     skid_data_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   logic                    accept;
   logic                    out_take;

   // Threshold registers.
   ucm_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .thresholds (thresholds)
   );

   // Feature datapath and offspring state.
   ucm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_ch     (req_ch),
      .thresholds (thresholds),
      .result     (result)
   );

   assign req_ch.ready = ~skid_valid_ff;
   assign accept       = req_ch.valid & req_ch.ready;
   assign out_take     = out_valid_ff & rsp_ch.ready;

   // Output register with a skid stage behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   // Valid flags are reset; the payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Drive the result channel from the output register.
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.child_a_bit   = out_data_ff.child_a_bit;
   assign rsp_ch.child_b_bit   = out_data_ff.child_b_bit;
   assign rsp_ch.two_children  = out_data_ff.two_children;
   assign rsp_ch.last_result   = out_data_ff.last_result;
   assign rsp_ch.count_a       = out_data_ff.count_a;
   assign rsp_ch.count_b       = out_data_ff.count_b;
   assign rsp_ch.force_a       = out_data_ff.force_a;
   assign rsp_ch.force_b       = out_data_ff.force_b;
   assign rsp_ch.force_index_a = out_data_ff.force_index_a;
   assign rsp_ch.force_index_b = out_data_ff.force_index_b;

   // The skid register is only ever filled behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result with an empty output register");

   // Any accepted feature leaves a valid output register in the next cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted feature produced no result");

   // A stalled result with a full skid stage blocks new features.
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ch.ready) |=> !req_ch.ready)
      else $error("input accepted while both result registers are full");

   // Mutation has no second child.
   a_mutation_one_child: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.two_children) |->
      (!rsp_ch.child_b_bit && rsp_ch.count_b == '0 && !rsp_ch.force_b))
      else $error("second child reported in mutation mode");

   // A repaired child ends the offspring with exactly one bit set.
   a_repair_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.force_a) |->
      (rsp_ch.last_result && rsp_ch.count_a == ucm_pkg::COUNT_W'(1)))
      else $error("empty-child repair outside the last feature");

endmodule

// ----- tb/uniform_crossover_mutation_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uniform_crossover_mutation_unit_tb: self-checking bench of the offspring unit
// A table of hand-picked features with typed-in results comes first. A long
// all-ones crossover chromosome follows. Then random offspring run under several
// threshold settings. Random gaps are placed on the request side and random
// stalls on the result side. Every result transfer is compared field by field with
// its typed-in result or a local model of the crossover, mutation and repair logic.
// ----------------------------------------------------------------------------
module uniform_crossover_mutation_unit_tb;

   localparam int DRAW_MAX     = (1 << ucm_pkg::DRAW_W) - 1;
   localparam int THR_MAX      = (1 << ucm_pkg::THR_W) - 1;
   localparam int SPARE_REG_LO = int'(ucm_pkg::REG_SET_ONE_THR) + 1;
   localparam int SPARE_REG_HI = (1 << ucm_pkg::CSR_INDEX_W) - 1;
   localparam int PHASE_ITEMS  = 200;
   localparam int LONG_CHROMOSOME = 300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int MAX_PRINTED  = 100;

   // One feature as offered on the request channel.
   typedef struct packed {
      logic                        bit_a;
      logic                        bit_b;
      logic [ucm_pkg::DRAW_W-1:0]  draw_mode;
      logic [ucm_pkg::DRAW_W-1:0]  draw_main;
      logic [ucm_pkg::DRAW_W-1:0]  draw_second;
      logic [ucm_pkg::INDEX_W-1:0] fix_index_a;
      logic [ucm_pkg::INDEX_W-1:0] fix_index_b;
      logic                        first_feature;
      logic                        last_feature;
   } feature_item_type;

   // One row of the directed table; typed is set where the child is given by hand.
   typedef struct packed {
      feature_item_type    feature;
      logic                typed;
      ucm_pkg::result_type child;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   ucm_req_if req_ch ();
   ucm_rsp_if rsp_ch ();
   ucm_csr_if csr_ch ();

   uniform_crossover_mutation_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   // Model state: thresholds, offspring mode and running ones counts.
   ucm_pkg::thresholds_type     thr_now;
   logic                        two_kids;
   logic [ucm_pkg::COUNT_W-1:0] ones_a;
   logic [ucm_pkg::COUNT_W-1:0] ones_b;

   ucm_pkg::result_type     pending_children [$];
   directed_row_type        directed_rows [$];
   ucm_pkg::thresholds_type threshold_plan [$];
   int            mismatch_count = 0;
   int            gapless_left = 0;
   int            quiet_cycles = 0;

   // Works out the child feature of one accepted request and advances the model.
   function automatic ucm_pkg::result_type breed_feature(input feature_item_type f);
      ucm_pkg::result_type r;
      logic                ca;
      logic                cb;
      r = '0;
      if (f.first_feature) begin
         two_kids = ({1'b0, f.draw_mode} < thr_now.crossover);
         ones_a = '0;
         ones_b = '0;
      end
      if (two_kids) begin
         if (f.bit_a != f.bit_b && {1'b0, f.draw_main} < thr_now.swap) begin
            ca = f.bit_b;
            cb = f.bit_a;
         end else begin
            ca = f.bit_a;
            cb = f.bit_b;
         end
      end else begin
         if ({1'b0, f.draw_main} < thr_now.mutate) begin
            ca = ({1'b0, f.draw_second} <= thr_now.set_one);
         end else begin
            ca = f.bit_a;
         end
         cb = 1'b0;
      end
      // Ones counts hold at the chromosome length.
      if (ca && ones_a < ucm_pkg::COUNT_CAP) begin
         ones_a = ones_a + ucm_pkg::COUNT_W'(1);
      end
      if (!two_kids) begin
         ones_b = '0;
      end else if (cb && ones_b < ucm_pkg::COUNT_CAP) begin
         ones_b = ones_b + ucm_pkg::COUNT_W'(1);
      end
      // An empty child gets one bit forced at its repair index.
      if (f.last_feature) begin
         if (ones_a == '0) begin
            r.force_a = 1'b1;
            r.force_index_a = f.fix_index_a;
            ones_a = ucm_pkg::COUNT_W'(1);
         end
         if (two_kids && ones_b == '0) begin
            r.force_b = 1'b1;
            r.force_index_b = f.fix_index_b;
            ones_b = ucm_pkg::COUNT_W'(1);
         end
      end
      r.child_a_bit  = ca;
      r.child_b_bit  = cb;
      r.two_children = two_kids;
      r.last_result  = f.last_feature;
      r.count_a      = ones_a;
      r.count_b      = ones_b;
      return r;
   endfunction

   function automatic feature_item_type make_feature(input int unsigned a, b, mode, main,
                                                     second, fix_a, fix_b, first, last);
      feature_item_type f;
      f.bit_a         = a[0];
      f.bit_b         = b[0];
      f.draw_mode     = ucm_pkg::DRAW_W'(mode);
      f.draw_main     = ucm_pkg::DRAW_W'(main);
      f.draw_second   = ucm_pkg::DRAW_W'(second);
      f.fix_index_a   = ucm_pkg::INDEX_W'(fix_a);
      f.fix_index_b   = ucm_pkg::INDEX_W'(fix_b);
      f.first_feature = first[0];
      f.last_feature  = last[0];
      return f;
   endfunction

   function automatic ucm_pkg::result_type make_child(input int unsigned ca, cb, two, last,
                                                      cnt_a, cnt_b, fa, fb, ia, ib);
      ucm_pkg::result_type r;
      r.child_a_bit   = ca[0];
      r.child_b_bit   = cb[0];
      r.two_children  = two[0];
      r.last_result   = last[0];
      r.count_a       = ucm_pkg::COUNT_W'(cnt_a);
      r.count_b       = ucm_pkg::COUNT_W'(cnt_b);
      r.force_a       = fa[0];
      r.force_b       = fb[0];
      r.force_index_a = ucm_pkg::INDEX_W'(ia);
      r.force_index_b = ucm_pkg::INDEX_W'(ib);
      return r;
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(input feature_item_type f, input logic typed,
                                   input ucm_pkg::result_type c);
      directed_row_type row;
      row.feature = f;
      row.typed   = typed;
      row.child   = c;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Appends one threshold setting to the plan of random phases.
   function automatic void add_plan(input ucm_pkg::thresholds_type t);
      threshold_plan.insert(threshold_plan.size(), t);
   endfunction

   // Random draw that often lands on or just under a threshold.
   function automatic logic [ucm_pkg::DRAW_W-1:0] pick_draw(
         input logic [ucm_pkg::THR_W-1:0] thr);
      int knee;
      knee = (thr > ucm_pkg::THR_W'(DRAW_MAX)) ? DRAW_MAX : int'(thr);
      case ($urandom_range(0, 9))
         0: return ucm_pkg::DRAW_W'(knee);
         1: return ucm_pkg::DRAW_W'((knee == 0) ? 0 : knee - 1);
         2: return ($urandom_range(0, 1) != 0) ? ucm_pkg::DRAW_W'(0)
                                                : ucm_pkg::DRAW_W'(DRAW_MAX);
         default: return ucm_pkg::DRAW_W'($urandom);
      endcase
   endfunction

   // Idle cycles before the next request: mostly none, a few long, some gapless runs.
   function automatic int pick_send_gap();
      int r;
      if (gapless_left > 0) begin
         gapless_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         gapless_left = $urandom_range(50, 250);
         return 0;
      end
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   task automatic check_field(input string name, input int unsigned got, want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   // Offers one feature, waits for its transfer and files the expected child.
   task automatic send_feature(input feature_item_type f, input logic typed,
                               input ucm_pkg::result_type given);
      int                  gap;
      ucm_pkg::result_type predicted;
      gap = pick_send_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.bit_a         <= f.bit_a;
      req_ch.bit_b         <= f.bit_b;
      req_ch.draw_mode     <= f.draw_mode;
      req_ch.draw_main     <= f.draw_main;
      req_ch.draw_second   <= f.draw_second;
      req_ch.fix_index_a   <= f.fix_index_a;
      req_ch.fix_index_b   <= f.fix_index_b;
      req_ch.first_feature <= f.first_feature;
      req_ch.last_feature  <= f.last_feature;
      do @(posedge clock); while (!req_ch.ready);
      predicted = breed_feature(f);
      pending_children.insert(pending_children.size(), typed ? given : predicted);
   endtask

   task automatic drain_children();
      while (pending_children.size() != 0) @(posedge clock);
   endtask

   // Writes all four thresholds, then a register index that holds nothing.
   task automatic load_thresholds(input ucm_pkg::thresholds_type t);
      logic [ucm_pkg::CSR_INDEX_W-1:0] idx [5];
      logic [ucm_pkg::THR_W-1:0]       val [5];
      idx[0] = ucm_pkg::REG_CROSSOVER_THR;
      idx[1] = ucm_pkg::REG_SWAP_THR;
      idx[2] = ucm_pkg::REG_MUTATE_THR;
      idx[3] = ucm_pkg::REG_SET_ONE_THR;
      idx[4] = ucm_pkg::CSR_INDEX_W'($urandom_range(SPARE_REG_LO, SPARE_REG_HI));
      val[0] = t.crossover;
      val[1] = t.swap;
      val[2] = t.mutate;
      val[3] = t.set_one;
      val[4] = ucm_pkg::THR_W'($urandom);
      for (int i = 0; i < 5; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[i];
         csr_ch.data  <= val[i];
         do @(posedge clock); while (!csr_ch.ready);
         case (idx[i])
            ucm_pkg::REG_CROSSOVER_THR: thr_now.crossover = val[i];
            ucm_pkg::REG_SWAP_THR:      thr_now.swap      = val[i];
            ucm_pkg::REG_MUTATE_THR:    thr_now.mutate    = val[i];
            ucm_pkg::REG_SET_ONE_THR:   thr_now.set_one   = val[i];
            default: ;
         endcase
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Mostly whole offspring with random content; the rest carry random marks.
   task automatic run_random_offspring(input int items);
      feature_item_type f;
      int               sent;
      int               len;
      int               density;
      logic             broken;
      sent = 0;
      while (sent < items) begin
         broken = ($urandom_range(0, 99) < 12);
         if (broken || $urandom_range(0, 99) < 85) begin
            len = $urandom_range(1, 24);
         end else begin
            len = $urandom_range(25, 300);
         end
         case ($urandom_range(0, 3))
            0: density = 0;
            1: density = 10;
            2: density = 50;
            default: density = 90;
         endcase
         for (int k = 0; k < len; k++) begin
            f.bit_a       = ($urandom_range(0, 99) < density);
            f.bit_b       = ($urandom_range(0, 99) < density);
            f.draw_mode   = pick_draw(thr_now.crossover);
            f.draw_main   = ($urandom_range(0, 1) != 0) ? pick_draw(thr_now.swap)
                                                        : pick_draw(thr_now.mutate);
            f.draw_second = pick_draw(thr_now.set_one);
            f.fix_index_a = ucm_pkg::INDEX_W'($urandom);
            f.fix_index_b = ucm_pkg::INDEX_W'($urandom);
            if (broken) begin
               f.first_feature = ($urandom_range(0, 1) != 0);
               f.last_feature  = ($urandom_range(0, 1) != 0);
            end else begin
               f.first_feature = (k == 0);
               f.last_feature  = (k == len - 1);
            end
            send_feature(f, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // Result side: ready mostly high, short and long stalls, some stall-free runs.
   initial begin : result_ready
      int stall_left;
      int free_left;
      int r;
      stall_left = 0;
      free_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (free_left > 0) begin
            free_left--;
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
               free_left = $urandom_range(50, 300);
               rsp_ch.ready <= 1'b1;
            end else if (r < 60) begin
               rsp_ch.ready <= 1'b1;
            end else if (r < 90) begin
               stall_left = $urandom_range(0, 2);
               rsp_ch.ready <= 1'b0;
            end else begin
               stall_left = $urandom_range(7, 39);
               rsp_ch.ready <= 1'b0;
            end
         end
      end
   end

   // Each result transfer is matched against the oldest expected child.
   always @(posedge clock) begin : child_check
      ucm_pkg::result_type got;
      ucm_pkg::result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         got = '{child_a_bit: rsp_ch.child_a_bit, child_b_bit: rsp_ch.child_b_bit,
                 two_children: rsp_ch.two_children, last_result: rsp_ch.last_result,
                 count_a: rsp_ch.count_a, count_b: rsp_ch.count_b,
                 force_a: rsp_ch.force_a, force_b: rsp_ch.force_b,
                 force_index_a: rsp_ch.force_index_a,
                 force_index_b: rsp_ch.force_index_b};
         if (pending_children.size() == 0) begin
            report_mismatch("result transfer with no child expected");
         end else begin
            want = pending_children.pop_front();
            check_field("child_a_bit", got.child_a_bit, want.child_a_bit);
            check_field("child_b_bit", got.child_b_bit, want.child_b_bit);
            check_field("two_children", got.two_children, want.two_children);
            check_field("last_result", got.last_result, want.last_result);
            check_field("count_a", got.count_a, want.count_a);
            check_field("count_b", got.count_b, want.count_b);
            check_field("force_a", got.force_a, want.force_a);
            check_field("force_b", got.force_b, want.force_b);
            check_field("force_index_a", got.force_index_a, want.force_index_a);
            check_field("force_index_b", got.force_index_b, want.force_index_b);
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d children outstanding",
                  QUIET_LIMIT, pending_children.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Main sequence: reset, directed table, long chromosome, random phases.
   initial begin : stimulus
      feature_item_type f;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.bit_a         <= 1'b0;
      req_ch.bit_b         <= 1'b0;
      req_ch.draw_mode     <= '0;
      req_ch.draw_main     <= '0;
      req_ch.draw_second   <= '0;
      req_ch.fix_index_a   <= '0;
      req_ch.fix_index_b   <= '0;
      req_ch.first_feature <= 1'b0;
      req_ch.last_feature  <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= '0;
      csr_ch.data          <= '0;
      thr_now = '{crossover: ucm_pkg::CROSSOVER_THR_RST, swap: ucm_pkg::SWAP_THR_RST,
                  mutate: ucm_pkg::MUTATE_THR_RST, set_one: ucm_pkg::SET_ONE_THR_RST};
      two_kids = 1'b0;
      ones_a = '0;
      ones_b = '0;

      // Directed table under the reset thresholds. Feature fields run
      // a, b, mode, main, second, fix_a, fix_b, first, last.
      // No first feature since reset: mutation mode, counts from zero.
      add_row(make_feature(1, 1, 0, 65535, 65535, 0, 0, 0, 0), 1'b1,
              make_child(1, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      add_row(make_feature(0, 1, 0, 65535, 0, 0, 0, 0, 1), 1'b1,
              make_child(0, 0, 0, 1, 1, 0, 0, 0, 0, 0));
      // Features after a last one without a new first keep counting.
      add_row(make_feature(1, 0, 0, 65535, 0, 0, 0, 0, 0), 1'b1,
              make_child(1, 0, 0, 0, 2, 0, 0, 0, 0, 0));
      // One-feature crossover offspring, both children empty and repaired.
      add_row(make_feature(0, 0, 0, 65535, 0, 4095, 2730, 1, 1), 1'b1,
              make_child(0, 0, 1, 1, 1, 1, 1, 1, 4095, 2730));
      // Crossover just under its threshold; swap decisions either side of the knee.
      add_row(make_feature(1, 0, 49151, 0, 0, 0, 0, 1, 0), 1'b1,
              make_child(0, 1, 1, 0, 0, 1, 0, 0, 0, 0));
      add_row(make_feature(1, 0, 0, 32768, 0, 0, 0, 0, 0), 1'b1,
              make_child(1, 0, 1, 0, 1, 1, 0, 0, 0, 0));
      add_row(make_feature(0, 1, 0, 32767, 0, 0, 0, 0, 0), 1'b1,
              make_child(1, 0, 1, 0, 2, 1, 0, 0, 0, 0));
      add_row(make_feature(1, 1, 0, 0, 0, 0, 0, 0, 1), 1'b1,
              make_child(1, 1, 1, 1, 3, 2, 0, 0, 0, 0));
      // Mode draw equal to the crossover threshold gives mutation.
      add_row(make_feature(0, 1, 49152, 6553, 655, 0, 0, 1, 0), 1'b1,
              make_child(1, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      add_row(make_feature(1, 0, 0, 6553, 656, 0, 0, 0, 0), 1'b1,
              make_child(0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      add_row(make_feature(1, 1, 65535, 6554, 0, 0, 0, 0, 0), 1'b1,
              make_child(1, 0, 0, 0, 2, 0, 0, 0, 0, 0));
      // Empty mutation child repaired at index zero; the second child stays absent.
      add_row(make_feature(0, 0, 65535, 65535, 0, 0, 0, 1, 0), 1'b1,
              make_child(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(make_feature(0, 1, 0, 65535, 0, 0, 4095, 0, 1), 1'b1,
              make_child(0, 0, 0, 1, 1, 0, 1, 0, 0, 0));
      // Crossover where only the second child ends empty.
      add_row(make_feature(1, 0, 0, 65535, 0, 0, 1234, 1, 1), 1'b1,
              make_child(1, 0, 1, 1, 1, 1, 0, 1, 0, 1234));
      add_row(make_feature(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              make_child(0, 0, 1, 0, 1, 1, 0, 0, 0, 0));
      // Mutated bit set by the lowest second draw, cleared by the highest.
      add_row(make_feature(0, 0, 65535, 0, 0, 0, 0, 1, 1), 1'b1,
              make_child(1, 0, 0, 1, 1, 0, 0, 0, 0, 0));
      add_row(make_feature(1, 1, 65535, 0, 65535, 100, 200, 1, 1), 1'b1,
              make_child(0, 0, 0, 1, 1, 0, 1, 0, 100, 0));
      add_row(make_feature(1, 0, 12345, 20000, 300, 17, 99, 1, 0), 1'b0,
              ucm_pkg::result_type'('0));
      add_row(make_feature(0, 1, 0, 40000, 700, 0, 0, 0, 0), 1'b0,
              ucm_pkg::result_type'('0));
      add_row(make_feature(1, 1, 0, 3000, 650, 3333, 444, 0, 1), 1'b0,
              ucm_pkg::result_type'('0));

      // Threshold settings for the random phases, extremes among them.
      add_plan('{crossover: ucm_pkg::THR_W'(0), swap: ucm_pkg::THR_W'(0),
                 mutate: ucm_pkg::THR_W'(0), set_one: ucm_pkg::THR_W'(0)});
      add_plan('{crossover: ucm_pkg::THR_W'(65536), swap: ucm_pkg::THR_W'(65536),
                 mutate: ucm_pkg::THR_W'(65536), set_one: ucm_pkg::THR_W'(65536)});
      add_plan('{crossover: ucm_pkg::THR_W'(0), swap: ucm_pkg::THR_W'(65536),
                 mutate: ucm_pkg::THR_W'(65536), set_one: ucm_pkg::THR_W'(0)});
      add_plan('{crossover: ucm_pkg::THR_W'(THR_MAX), swap: ucm_pkg::THR_W'(0),
                 mutate: ucm_pkg::THR_W'(THR_MAX), set_one: ucm_pkg::THR_W'(THR_MAX)});
      add_plan('{crossover: ucm_pkg::THR_W'(32768), swap: ucm_pkg::THR_W'(DRAW_MAX),
                 mutate: ucm_pkg::THR_W'(32768), set_one: ucm_pkg::THR_W'(32768)});
      add_plan('{crossover: ucm_pkg::THR_W'($urandom_range(0, 65536)),
                 swap: ucm_pkg::THR_W'($urandom_range(0, 65536)),
                 mutate: ucm_pkg::THR_W'($urandom_range(0, 65536)),
                 set_one: ucm_pkg::THR_W'($urandom_range(0, 65536))});

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         send_feature(directed_rows[k].feature, directed_rows[k].typed,
                      directed_rows[k].child);
      end

      // A long chromosome of all ones, in crossover.
      for (int k = 0; k < LONG_CHROMOSOME; k++) begin
         f = make_feature(1, 1, 0, $urandom, $urandom, $urandom, $urandom,
                          (k == 0), (k == LONG_CHROMOSOME - 1));
         send_feature(f, 1'b0, '0);
      end

      run_random_offspring(PHASE_ITEMS);
      foreach (threshold_plan[p]) begin
         req_ch.valid <= 1'b0;
         drain_children();
         load_thresholds(threshold_plan[p]);
         run_random_offspring(PHASE_ITEMS);
      end

      // Let the last results arrive and watch for stray transfers afterwards.
      req_ch.valid <= 1'b0;
      drain_children();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
